@@ rtl/mvm_pkg.sv @@
// Package: shared constants and types for the matrix-vector multiply device
`timescale 1ns / 1ps
package mvm_pkg;
   localparam int MAX_DIM_DEFAULT   = 10;
   localparam int DEVICE_ID_DEFAULT = 49568;
   localparam logic [31:0] FILL_PATTERN = 32'hA0E0A0E0;
   localparam logic [10:0] MAT_BASE  = 11'h000;
   localparam logic [10:0] VEC_BASE  = 11'h200;
   localparam logic [10:0] RES_BASE  = 11'h300;
   localparam logic [10:0] CTRL_ADDR = 11'h400;
   localparam logic [10:0] SIZE_ADDR = 11'h410;
   localparam logic [10:0] STAT_ADDR = 11'h420;
   localparam logic [10:0] ID_ADDR   = 11'h430;
   localparam logic [31:0] CTRL_RESET = 32'h1;
   localparam int DIM_RESET = 3;
   localparam int C_ENABLE = 0;
   localparam int C_IRQ_EN = 1;
   localparam int C_START  = 2;
   localparam int C_RSTAT  = 3;

   typedef enum logic [3:0] {
      OP_NONE, OP_RD_MAT, OP_RD_VEC, OP_RD_RES, OP_RD_CTRL, OP_RD_SIZE, OP_RD_STAT,
      OP_RD_ID, OP_RD_FILL, OP_RD_ZERO, OP_WR_MAT, OP_WR_VEC, OP_WR_SIZE, OP_WR_CTRL
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  idx;
      logic [31:0] data;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RDWAIT, ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC, ST_DONE
   } state_type;
endpackage

@@ rtl/mvm_front.sv @@
// Front end: decodes one bus access into a command and holds it in a small queue
`timescale 1ns / 1ps
module mvm_front #(
   parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic             mode,
   input  logic [10:0]      address,
   input  logic [31:0]      write_data,
   input  logic             enabled,
   output logic             q_valid,
   output mvm_pkg::cmd_type q_cmd,
   input  logic             q_pop
);
   localparam int MW = MAX_DIM * MAX_DIM;
   mvm_pkg::cmd_type cmd;
   mvm_pkg::cmd_type q_ff [2];
   mvm_pkg::cmd_type q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [10:0] off_vec, off_res;

   always_comb begin
      off_vec = address - mvm_pkg::VEC_BASE;
      off_res = address - mvm_pkg::RES_BASE;
      cmd.data = write_data;
      cmd.idx  = '0;
      cmd.op   = mvm_pkg::OP_NONE;
      if (mode) begin
         if (address[1:0] == 2'b00 && 32'(address[10:2]) < MW) begin
            cmd.op = mvm_pkg::OP_WR_MAT; cmd.idx = address[9:2];
         end else if (address >= mvm_pkg::VEC_BASE && address[1:0] == 2'b00
                      && 32'(off_vec[10:2]) < MAX_DIM) begin
            cmd.op = mvm_pkg::OP_WR_VEC; cmd.idx = off_vec[9:2];
         end else if (address == mvm_pkg::SIZE_ADDR) begin
            cmd.op = mvm_pkg::OP_WR_SIZE;
         end else if (address == mvm_pkg::CTRL_ADDR) begin
            cmd.op = mvm_pkg::OP_WR_CTRL;
         end
      end else if (!enabled) begin
         cmd.op = mvm_pkg::OP_RD_ZERO;
      end else if (address[1:0] == 2'b00 && 32'(address[10:2]) < MW) begin
         cmd.op = mvm_pkg::OP_RD_MAT; cmd.idx = address[9:2];
      end else if (address >= mvm_pkg::VEC_BASE && address[1:0] == 2'b00
                   && 32'(off_vec[10:2]) < MAX_DIM) begin
         cmd.op = mvm_pkg::OP_RD_VEC; cmd.idx = off_vec[9:2];
      end else if (address >= mvm_pkg::RES_BASE && address[1:0] == 2'b00
                   && 32'(off_res[10:2]) < MAX_DIM) begin
         cmd.op = mvm_pkg::OP_RD_RES; cmd.idx = off_res[9:2];
      end else if (address == mvm_pkg::CTRL_ADDR) begin
         cmd.op = mvm_pkg::OP_RD_CTRL;
      end else if (address == mvm_pkg::SIZE_ADDR) begin
         cmd.op = mvm_pkg::OP_RD_SIZE;
      end else if (address == mvm_pkg::STAT_ADDR) begin
         cmd.op = mvm_pkg::OP_RD_STAT;
      end else if (address == mvm_pkg::ID_ADDR) begin
         cmd.op = mvm_pkg::OP_RD_ID;
      end else begin
         cmd.op = mvm_pkg::OP_RD_FILL;
      end
   end

   always_comb begin
      q0_in  = q_ff[0];
      q1_in  = q_ff[1];
      cnt_in = cnt_ff;
      if (q_pop) begin
         q0_in = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (take) begin
         if (cnt_in == 2'd0) q0_in = cmd;
         else q1_in = cmd;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = q_ff[0];
endmodule

@@ rtl/mvm_back.sv @@
// Back end: register file, matrix memory and the multiply-accumulate sequencer
`timescale 1ns / 1ps
module mvm_back #(
   parameter int MAX_DIM   = mvm_pkg::MAX_DIM_DEFAULT,
   parameter int DEVICE_ID = mvm_pkg::DEVICE_ID_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  mvm_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             idle,
   output logic             enabled,
   output logic             rsp_valid,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_irq_level
);
   localparam int MW = MAX_DIM * MAX_DIM;
   localparam int AW = (MW > 1) ? $clog2(MW) : 1;
   localparam int VW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);

   logic [31:0] mat_mem [MW];
   logic [MW-1:0] mat_vld_ff;
   logic [31:0] vec_ff [MAX_DIM];
   logic [31:0] res_ff [MAX_DIM];
   logic [31:0] ctrl_ff;
   logic [DW-1:0] dim_ff;
   logic [1:0] stat_ff;
   logic irq_ff, irq_in;
   mvm_pkg::state_type state_ff, state_in;
   mvm_pkg::cmd_type cur_ff;
   logic [31:0] mrd_ff, prod_ff, acc_ff, vsel_ff;
   logic mvld_ff;
   logic [AW-1:0] maddr_ff, maddr_in;
   logic [VW-1:0] r_ff, c_ff;
   logic [31:0] rdat_ff;
   logic rv_ff;
   logic mat_we;
   logic [AW-1:0] mat_wa;

   assign enabled = ctrl_ff[mvm_pkg::C_ENABLE];
   assign idle = (state_ff == mvm_pkg::ST_IDLE) && !q_valid;
   assign q_pop = (state_ff == mvm_pkg::ST_IDLE) && q_valid;
   assign mat_we = q_pop && q_cmd.op == mvm_pkg::OP_WR_MAT;
   assign mat_wa = q_cmd.idx[AW-1:0];

   always_comb begin
      state_in = state_ff;
      maddr_in = maddr_ff;
      case (state_ff)
         mvm_pkg::ST_IDLE: begin
            if (q_pop) begin
               maddr_in = q_cmd.idx[AW-1:0];
               if (q_cmd.op == mvm_pkg::OP_WR_CTRL && q_cmd.data[mvm_pkg::C_START]
                   && dim_ff != '0) begin
                  maddr_in = '0;
                  state_in = mvm_pkg::ST_MAC_RD;
               end else if (q_cmd.op == mvm_pkg::OP_RD_MAT) begin
                  state_in = mvm_pkg::ST_RDWAIT;
               end else begin
                  state_in = mvm_pkg::ST_DONE;
               end
            end
         end
         mvm_pkg::ST_RDWAIT: state_in = mvm_pkg::ST_DONE;
         mvm_pkg::ST_MAC_RD: begin
            state_in = mvm_pkg::ST_MAC_MUL;
         end
         mvm_pkg::ST_MAC_MUL: state_in = mvm_pkg::ST_MAC_ACC;
         mvm_pkg::ST_MAC_ACC: begin
            maddr_in = maddr_ff + AW'(1);
            if (DW'(c_ff) == dim_ff - DW'(1) && DW'(r_ff) == dim_ff - DW'(1))
               state_in = mvm_pkg::ST_DONE;
            else
               state_in = mvm_pkg::ST_MAC_RD;
         end
         mvm_pkg::ST_DONE: state_in = mvm_pkg::ST_IDLE;
         default: state_in = mvm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= q_cmd.data;
      mrd_ff <= mat_mem[maddr_in];
      mvld_ff <= mat_vld_ff[maddr_in];
   end

   always_comb begin
      irq_in = irq_ff;
      if (state_ff == mvm_pkg::ST_DONE) begin
         case (cur_ff.op)
            mvm_pkg::OP_RD_STAT: irq_in = 1'b0;
            mvm_pkg::OP_WR_CTRL: begin
               if (cur_ff.data[mvm_pkg::C_START]) begin
                  if (cur_ff.data[mvm_pkg::C_IRQ_EN]) irq_in = 1'b1;
               end else if (cur_ff.data[mvm_pkg::C_RSTAT]) begin
                  irq_in = 1'b0;
               end
            end
            default: irq_in = irq_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      maddr_ff <= maddr_in;
      irq_ff <= irq_in;
      rv_ff <= (state_ff == mvm_pkg::ST_DONE);
      if (q_pop) cur_ff <= q_cmd;
      if (state_ff == mvm_pkg::ST_MAC_RD) vsel_ff <= vec_ff[c_ff];
      if (state_ff == mvm_pkg::ST_MAC_MUL) prod_ff <= (mvld_ff ? mrd_ff : 32'd0) * vsel_ff;
      if (state_ff == mvm_pkg::ST_DONE) begin
         case (cur_ff.op)
            mvm_pkg::OP_RD_MAT:  rdat_ff <= mvld_ff ? mrd_ff : 32'd0;
            mvm_pkg::OP_RD_VEC:  rdat_ff <= vec_ff[cur_ff.idx[VW-1:0]];
            mvm_pkg::OP_RD_RES:  rdat_ff <= res_ff[cur_ff.idx[VW-1:0]];
            mvm_pkg::OP_RD_CTRL: rdat_ff <= ctrl_ff;
            mvm_pkg::OP_RD_SIZE: rdat_ff <= 32'(dim_ff);
            mvm_pkg::OP_RD_STAT: rdat_ff <= {30'd0, stat_ff};
            mvm_pkg::OP_RD_ID:   rdat_ff <= 32'(DEVICE_ID & 16'hFFFF);
            mvm_pkg::OP_RD_FILL: rdat_ff <= mvm_pkg::FILL_PATTERN;
            default:             rdat_ff <= 32'd0;
         endcase
      end
      if (state_ff == mvm_pkg::ST_IDLE) begin
         r_ff <= '0; c_ff <= '0; acc_ff <= '0;
      end
      if (state_ff == mvm_pkg::ST_MAC_ACC) begin
         if (DW'(c_ff) == dim_ff - DW'(1)) begin
            res_ff[r_ff] <= acc_ff + prod_ff;
            acc_ff <= '0;
            c_ff <= '0;
            r_ff <= r_ff + VW'(1);
         end else begin
            acc_ff <= acc_ff + prod_ff;
            c_ff <= c_ff + VW'(1);
         end
      end
      if (q_pop) begin
         case (q_cmd.op)
            mvm_pkg::OP_WR_VEC: vec_ff[q_cmd.idx[VW-1:0]] <= q_cmd.data;
            mvm_pkg::OP_WR_SIZE:
               dim_ff <= (q_cmd.data <= 32'(MAX_DIM)) ? q_cmd.data[DW-1:0] : DW'(MAX_DIM);
            mvm_pkg::OP_WR_CTRL: begin
               ctrl_ff <= q_cmd.data;
               if (q_cmd.data[mvm_pkg::C_START]) stat_ff <= 2'b11;
               else if (q_cmd.data[mvm_pkg::C_RSTAT]) stat_ff <= 2'b00;
            end
            default: ;
         endcase
      end
      if (mat_we) mat_vld_ff[mat_wa] <= 1'b1;
      if (reset) begin
         state_ff <= mvm_pkg::ST_IDLE;
         irq_ff <= 1'b0;
         rv_ff <= 1'b0;
         ctrl_ff <= mvm_pkg::CTRL_RESET;
         dim_ff <= DW'(mvm_pkg::DIM_RESET);
         stat_ff <= 2'b00;
         mat_vld_ff <= '0;
         for (int i = 0; i < MAX_DIM; i++) begin
            vec_ff[i] <= '0;
            res_ff[i] <= '0;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_read_data = rdat_ff;
   assign rsp_irq_level = irq_ff;
endmodule

@@ rtl/matrix_vector_multiply_device.sv @@
// Top level: matrix-vector multiply device register window
//  channel   | ports                                   | direction
//  request   | start, busy, req_mode/address/write_data | in; busy out
//  response  | rsp_valid, rsp_read_data, rsp_irq_level  | out
// A start command walks dimension^2 multiply-accumulates through the
// single matrix memory read port and multiplier. busy is high while a
// beat is queued or at work; reset clears the vector and result stores
// and marks every matrix word invalid.
`timescale 1ns / 1ps
module matrix_vector_multiply_device #(
   parameter int MAX_DIM   = mvm_pkg::MAX_DIM_DEFAULT,
   parameter int DEVICE_ID = mvm_pkg::DEVICE_ID_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [10:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_level
);
   logic q_valid, q_pop, idle, enabled, busy_ff, take;
   mvm_pkg::cmd_type q_cmd;

   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (take) busy_ff <= 1'b1;
      else if (rsp_valid) busy_ff <= 1'b0;
   end
   assign busy = busy_ff || !idle;

   mvm_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock, .reset, .take, .mode(req_mode), .address(req_address),
      .write_data(req_write_data), .enabled, .q_valid, .q_cmd, .q_pop
   );

   mvm_back #(.MAX_DIM(MAX_DIM), .DEVICE_ID(DEVICE_ID)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .idle, .enabled,
      .rsp_valid, .rsp_read_data, .rsp_irq_level
   );
endmodule

@@ rtl/mvm_checker.sv @@
// Checker: port-level properties of the matrix-vector multiply device
`timescale 1ns / 1ps
module mvm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic [31:0] rsp_read_data
);
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode |-> ##3 rsp_valid && rsp_read_data == 32'd0
         || !rsp_valid) else $error("write returned data");
   a_rsp_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without request");
endmodule

bind matrix_vector_multiply_device mvm_checker u_mvm_checker (
   .clock, .reset, .start, .busy, .req_mode, .rsp_valid, .rsp_read_data
);
